/* rtl/ssa_pkg.sv */
// Shared types and constants of the size-class slab allocator.
package ssa_pkg;

	localparam int REQ_W  = 16;
	localparam int ADDR_W = 20;
	localparam int CLS_W  = 4;
	localparam int STAT_W = 2;
	localparam int CFG_W  = 5;

	localparam int HEADER_BYTES = 8;

	// descriptor states
	localparam logic [1:0] ST_EMPTY   = 2'd0;
	localparam logic [1:0] ST_PARTIAL = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OOM = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BIG = 2'd2;

	// opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic             found;
		logic [CLS_W-1:0] cls;
	} class_pick_t;

endpackage

/* rtl/ssa_req_if.sv */
// Request channel: opcode, request size and block address.
interface ssa_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [15:0] request_bytes;
	logic [19:0] block_address;

	modport source (output valid, output opcode, output request_bytes, output block_address,
		input ready);
	modport sink (input valid, input opcode, input request_bytes, input block_address,
		output ready);
endinterface

/* rtl/ssa_rsp_if.sv */
// Result channel: granted address, class and status.
interface ssa_rsp_if;
	logic        valid;
	logic        ready;
	logic [19:0] granted_address;
	logic [3:0]  granted_class;
	logic [1:0]  status;

	modport source (output valid, output granted_address, output granted_class, output status,
		input ready);
	modport sink (input valid, input granted_address, input granted_class, input status,
		output ready);
endinterface

/* rtl/ssa_ram.sv */
// Generic simple dual-port RAM, registered write-first read.
module ssa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port, and read that sees a same-cycle write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && waddr == raddr) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* rtl/ssa_class_sel.sv */
// Size-class picker: smallest class whose block holds request plus header.
module ssa_class_sel #(
	parameter int MIN_CLASS_LOG2 = 6,
	parameter int MAX_CLASS      = 9
) (
	input  logic [ssa_pkg::REQ_W-1:0] request_bytes,
	output ssa_pkg::class_pick_t      pick
);
	import ssa_pkg::*;

	logic [REQ_W:0] need;

	assign need = (REQ_W+1)'(request_bytes) + (REQ_W+1)'(HEADER_BYTES);

	// downward scan leaves the smallest fitting class
	always_comb begin
		pick = '0;
		for (int c = MAX_CLASS; c >= 0; c--) begin
			if ((33'(1) << (MIN_CLASS_LOG2 + c)) >= 33'(need)) begin
				pick.found = 1'b1;
				pick.cls   = CLS_W'(c);
			end
		end
	end
endmodule

/* rtl/size_class_slab_allocator.sv */
// Size-class slab allocator: top level with the control sequencer.
//
// One transaction at a time. An allocate served from a partial active descriptor goes
// through class pick, descriptor read, block-list read and write back. Each stale
// descriptor skipped on the way costs one more descriptor-RAM read. Carving a fresh
// superblock walks its block list one entry per cycle. A free goes through the
// superblock-owner read, descriptor read and write back. The next request is accepted
// in the cycle after the result is loaded into the output register. A write to the
// pool-size register reinitializes the allocator heads, class tables and sequencer; no
// clearing pass is needed, because free superblocks and descriptors are handed out
// from a fresh counter behind the free stack.
module size_class_slab_allocator #(
	parameter int NUM_SUPERBLOCKS  = 16,
	parameter int NUM_DESCRIPTORS  = 16,
	parameter int SUPERBLOCK_BYTES = 65536,
	parameter int NUM_CLASSES      = 16,
	parameter int MIN_CLASS_LOG2   = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	ssa_req_if.sink                   req,
	ssa_rsp_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic [ssa_pkg::CFG_W-1:0] cfg_wdata
);
	import ssa_pkg::*;

	localparam int SBW      = $clog2(NUM_SUPERBLOCKS);
	localparam int SLW      = SBW + 1;
	localparam int DW       = $clog2(NUM_DESCRIPTORS);
	localparam int DLW      = DW + 1;
	localparam int SB_LOG2  = $clog2(SUPERBLOCK_BYTES);
	localparam int BIW      = SB_LOG2 - MIN_CLASS_LOG2;
	localparam int BLK_D    = NUM_SUPERBLOCKS << BIW;
	localparam int CMAX_FIT = SB_LOG2 - 2 - MIN_CLASS_LOG2;
	localparam int CMAX     = (NUM_CLASSES - 1 < CMAX_FIT) ? NUM_CLASSES - 1 : CMAX_FIT;
	localparam int CIW      = $clog2(NUM_CLASSES);
	localparam int NW       = $clog2(NUM_DESCRIPTORS + 3);
	localparam int RST_USE  = (16 > NUM_SUPERBLOCKS) ? NUM_SUPERBLOCKS : 16;
	localparam logic [20:0] OFF_MASK = 21'((64'(1) << SB_LOG2) - 1);

	typedef struct packed {
		logic [DLW-1:0]   link;
		logic [BIW-1:0]   nxt;
		logic [BIW-1:0]   fc;
		logic [1:0]       st;
		logic [SBW-1:0]   sb;
		logic [CLS_W-1:0] cls;
	} desc_t;

	typedef struct packed {
		logic [DW-1:0]  owner;
		logic [SLW-1:0] link;
	} sbw_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CLS, S_DCHK, S_SERVE, S_NEW, S_NEW2, S_CARVE, S_CFIN,
		S_F0, S_F1, S_F2, S_OUT
	} state_t;

	// blocks in a class's superblock
	function automatic logic [BIW:0] m_of(input logic [CLS_W-1:0] c);
		m_of = (BIW+1)'(SUPERBLOCK_BYTES >> (MIN_CLASS_LOG2 + int'(c)));
	endfunction

	state_t           state_q;
	logic [SLW-1:0]   cfg_q;
	logic [SLW-1:0]   sbstk_q, sbfresh_q;
	logic [DLW-1:0]   dstk_q, dfresh_q;
	logic [DLW-1:0]   active_q [NUM_CLASSES];
	logic [DLW-1:0]   partial_q [NUM_CLASSES];
	logic             big_q, pop_q;
	logic [CLS_W-1:0] cls_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DLW-1:0]   d_q;
	logic [SBW-1:0]   s_q;
	logic [DW-1:0]    k_q;
	logic [NW-1:0]    n_q;
	desc_t            desc_q;
	sbw_t             sbw_q;
	logic [BIW-1:0]   blk_q;
	logic [BIW:0]     i_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [CLS_W-1:0] res_cls_q;
	logic [STAT_W-1:0] res_st_q;
	logic             ov_q;
	logic [ADDR_W-1:0] oaddr_q;
	logic [CLS_W-1:0] ocls_q;
	logic [STAT_W-1:0] ost_q;

	class_pick_t      pick;

	// RAM ports
	logic             d_we;
	logic [DW-1:0]    d_wa, d_ra;
	desc_t            d_wd, d_rd;
	logic             s_we;
	logic [SBW-1:0]   s_wa, s_ra;
	sbw_t             s_wd, s_rd;
	logic             b_we;
	logic [SBW+BIW-1:0] b_wa, b_ra;
	logic [BIW-1:0]   b_wd, b_rd;

	// decoded helpers
	logic [CIW-1:0]   ci, fci;
	logic [BIW:0]     mc, mf;
	logic [DLW-1:0]   ph;
	logic [BIW-1:0]   sblk;
	logic [20:0]      sfull, off, off8, amask, blk21;
	logic [4:0]       lg;
	logic             fok;
	logic [SLW-1:0]   cfg_sat;

	ssa_class_sel #(.MIN_CLASS_LOG2(MIN_CLASS_LOG2), .MAX_CLASS(CMAX)) u_cls (
		.request_bytes(req.request_bytes), .pick(pick)
	);

	ssa_ram #(.WIDTH($bits(desc_t)), .DEPTH(NUM_DESCRIPTORS)) u_desc (
		.clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd)
	);
	ssa_ram #(.WIDTH($bits(sbw_t)), .DEPTH(NUM_SUPERBLOCKS)) u_sb (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
	);
	ssa_ram #(.WIDTH(BIW), .DEPTH(BLK_D)) u_blk (
		.clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd)
	);

	assign req.ready           = (state_q == S_IDLE);
	assign rsp.valid           = ov_q;
	assign rsp.granted_address = oaddr_q;
	assign rsp.granted_class   = ocls_q;
	assign rsp.status          = ost_q;

	assign cfg_sat = (32'(cfg_wdata) > NUM_SUPERBLOCKS) ? SLW'(NUM_SUPERBLOCKS)
		: SLW'(cfg_wdata);

	// class indexes and per-class block counts
	assign ci   = cls_q[CIW-1:0];
	assign fci  = d_rd.cls[CIW-1:0];
	assign mc   = m_of(cls_q);
	assign mf   = m_of(d_rd.cls);
	assign ph   = pop_q ? d_rd.link : partial_q[ci];
	assign sblk = ({1'b0, d_rd.nxt} >= mc) ? '0 : d_rd.nxt;

	// free address decode
	assign sfull = {1'b0, addr_q} >> SB_LOG2;
	assign off   = {1'b0, addr_q} & OFF_MASK;
	assign off8  = off - 21'(HEADER_BYTES);
	assign lg    = 5'(MIN_CLASS_LOG2) + 5'(d_rd.cls);
	assign amask = (21'(1) << lg) - 21'(1);
	assign blk21 = off8 >> lg;
	assign fok   = d_rd.st != ST_EMPTY && d_rd.sb == s_q && 32'(d_rd.cls) < NUM_CLASSES
		&& off >= 21'(HEADER_BYTES) && (off8 & amask) == '0 && blk21 < 21'(mf);

	// RAM port control
	always_comb begin
		d_we = 1'b0; d_wa = '0; d_wd = desc_q; d_ra = '0;
		s_we = 1'b0; s_wa = s_q; s_wd = sbw_q; s_ra = '0;
		b_we = 1'b0; b_wa = '0; b_wd = '0; b_ra = '0;
		unique case (state_q)
			S_CLS: begin
				d_ra = DW'(active_q[ci] - 1'b1);
			end
			S_DCHK: begin
				if (d_rd.st == ST_PARTIAL) begin
					b_ra = {d_rd.sb, sblk};
				end else if (32'(n_q) <= NUM_DESCRIPTORS + 1) begin
					if (d_rd.st != ST_FULL) begin
						d_we      = 1'b1;
						d_wa      = DW'(d_q - 1'b1);
						d_wd      = d_rd;
						d_wd.st   = ST_EMPTY;
						d_wd.link = dstk_q;
					end
					d_ra = DW'(ph - 1'b1);
				end
			end
			S_SERVE: begin
				d_we    = 1'b1;
				d_wa    = DW'(d_q - 1'b1);
				d_wd.fc = (desc_q.fc != '0) ? desc_q.fc - 1'b1 : '0;
				d_wd.st = (d_wd.fc != '0) ? ST_PARTIAL : ST_FULL;
				d_wd.nxt = b_rd & BIW'(mc - 1'b1);
			end
			S_NEW: begin
				d_ra = DW'(dstk_q - 1'b1);
				s_ra = SBW'(sbstk_q - 1'b1);
			end
			S_NEW2: begin
				s_we       = 1'b1;
				s_wa       = (sbstk_q != '0) ? SBW'(sbstk_q - 1'b1) : SBW'(sbfresh_q - 1'b1);
				s_wd.owner = (dstk_q != '0) ? DW'(dstk_q - 1'b1) : DW'(dfresh_q);
				s_wd.link  = '0;
			end
			S_CARVE: begin
				b_we = 1'b1;
				b_wa = {s_q, i_q[BIW-1:0]};
				b_wd = (i_q + 1'b1 < mc) ? BIW'(i_q + 1'b1) : '0;
			end
			S_CFIN: begin
				d_we      = 1'b1;
				d_wa      = DW'(d_q - 1'b1);
				d_wd.link = (active_q[ci] != '0) ? partial_q[ci] : '0;
				d_wd.nxt  = BIW'(1);
				d_wd.fc   = BIW'(mc - 1'b1);
				d_wd.st   = ST_PARTIAL;
				d_wd.sb   = s_q;
				d_wd.cls  = cls_q;
			end
			S_F0: begin
				s_ra = sfull[SBW-1:0];
			end
			S_F1: begin
				d_ra = s_rd.owner;
			end
			S_F2: begin
				d_wa = k_q;
				d_wd = d_rd;
				if (fok) begin
					d_we = 1'b1;
					if (32'(d_rd.fc) >= 32'(mf) - 1) begin
						d_wd.st    = ST_EMPTY;
						d_wd.fc    = '0;
						d_wd.nxt   = '0;
						s_we       = 1'b1;
						s_wd.owner = sbw_q.owner;
						s_wd.link  = sbstk_q;
					end else begin
						b_we     = 1'b1;
						b_wa     = {s_q, blk21[BIW-1:0]};
						b_wd     = d_rd.nxt;
						d_wd.nxt = blk21[BIW-1:0];
						d_wd.fc  = d_rd.fc + 1'b1;
						d_wd.st  = ST_PARTIAL;
						if (d_rd.st == ST_FULL && active_q[fci] != DLW'(k_q) + 1'b1) begin
							d_wd.link = partial_q[fci];
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer, allocator heads, class tables and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cfg_q     <= SLW'(RST_USE);
			sbstk_q   <= '0;
			sbfresh_q <= SLW'(RST_USE);
			dstk_q    <= '0;
			dfresh_q  <= '0;
			ov_q      <= 1'b0;
			pop_q     <= 1'b0;
			n_q       <= '0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				active_q[c]  <= '0;
				partial_q[c] <= '0;
			end
		end else begin
			if (rsp.ready && state_q != S_OUT) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						addr_q     <= req.block_address;
						cls_q      <= pick.cls;
						big_q      <= !pick.found;
						res_addr_q <= '0;
						res_cls_q  <= '0;
						res_st_q   <= STAT_OK;
						state_q    <= (req.opcode == OP_FREE) ? S_F0 : S_CLS;
					end
				end
				S_CLS: begin
					n_q   <= '0;
					pop_q <= 1'b0;
					d_q   <= active_q[ci];
					if (big_q) begin
						res_st_q <= STAT_BIG;
						state_q  <= S_OUT;
					end else if (active_q[ci] == '0) begin
						state_q <= S_NEW;
					end else begin
						state_q <= S_DCHK;
					end
				end
				S_DCHK: begin
					desc_q <= d_rd;
					if (pop_q) begin
						partial_q[ci] <= d_rd.link;
					end
					if (d_rd.st == ST_PARTIAL) begin
						blk_q   <= sblk;
						s_q     <= d_rd.sb;
						state_q <= S_SERVE;
					end else if (32'(n_q) > NUM_DESCRIPTORS + 1) begin
						state_q <= S_NEW;
					end else begin
						if (d_rd.st != ST_FULL) begin
							dstk_q <= d_q;
						end
						active_q[ci] <= ph;
						n_q          <= n_q + 1'b1;
						d_q          <= ph;
						pop_q        <= (ph != '0);
						if (ph == '0) begin
							state_q <= S_NEW;
						end
					end
				end
				S_SERVE: begin
					res_addr_q <= ADDR_W'((32'(s_q) << SB_LOG2)
						+ (32'(blk_q) << (MIN_CLASS_LOG2 + int'(cls_q))) + HEADER_BYTES);
					res_cls_q  <= cls_q;
					state_q    <= S_OUT;
				end
				S_NEW: begin
					if ((dstk_q == '0 && 32'(dfresh_q) == NUM_DESCRIPTORS)
						|| (sbstk_q == '0 && sbfresh_q == '0)) begin
						res_cls_q <= cls_q;
						res_st_q  <= STAT_OOM;
						state_q   <= S_OUT;
					end else begin
						state_q <= S_NEW2;
					end
				end
				S_NEW2: begin
					if (dstk_q != '0) begin
						d_q    <= dstk_q;
						dstk_q <= d_rd.link;
					end else begin
						d_q      <= dfresh_q + 1'b1;
						dfresh_q <= dfresh_q + 1'b1;
					end
					if (sbstk_q != '0) begin
						s_q     <= SBW'(sbstk_q - 1'b1);
						sbstk_q <= s_rd.link;
					end else begin
						s_q       <= SBW'(sbfresh_q - 1'b1);
						sbfresh_q <= sbfresh_q - 1'b1;
					end
					i_q     <= '0;
					state_q <= S_CARVE;
				end
				S_CARVE: begin
					i_q <= i_q + 1'b1;
					if (i_q == mc - 1'b1) begin
						state_q <= S_CFIN;
					end
				end
				S_CFIN: begin
					if (active_q[ci] != '0) begin
						partial_q[ci] <= d_q;
					end else begin
						active_q[ci] <= d_q;
					end
					res_addr_q <= ADDR_W'((32'(s_q) << SB_LOG2) + HEADER_BYTES);
					res_cls_q  <= cls_q;
					state_q    <= S_OUT;
				end
				S_F0: begin
					s_q <= sfull[SBW-1:0];
					if (sfull >= 21'(cfg_q) || 32'(sfull) >= NUM_SUPERBLOCKS) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_F1;
					end
				end
				S_F1: begin
					k_q   <= s_rd.owner;
					sbw_q <= s_rd;
					state_q <= (32'(s_rd.owner) >= NUM_DESCRIPTORS) ? S_OUT : S_F2;
				end
				S_F2: begin
					if (fok) begin
						if (32'(d_rd.fc) >= 32'(mf) - 1) begin
							sbstk_q <= SLW'(s_q) + 1'b1;
						end else if (d_rd.st == ST_FULL
							&& active_q[fci] != DLW'(k_q) + 1'b1) begin
							partial_q[fci] <= DLW'(k_q) + 1'b1;
						end
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!ov_q || rsp.ready) begin
						ov_q    <= 1'b1;
						oaddr_q <= res_addr_q;
						ocls_q  <= res_cls_q;
						ost_q   <= res_st_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// pool reinitialization
			if (cfg_we) begin
				cfg_q     <= cfg_sat;
				sbstk_q   <= '0;
				sbfresh_q <= cfg_sat;
				dstk_q    <= '0;
				dfresh_q  <= '0;
				state_q   <= S_IDLE;
				for (int c = 0; c < NUM_CLASSES; c++) begin
					active_q[c]  <= '0;
					partial_q[c] <= '0;
				end
			end
		end
	end

	// a failed transaction never carries an address
	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != STAT_OK |-> rsp.granted_address == '0)
		else $error("failed transaction with nonzero address");

	// an oversized request reports class zero
	a_big_cls: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STAT_BIG |-> rsp.granted_class == '0)
		else $error("oversized request with nonzero class");

	// fresh superblocks never exceed the pool size
	a_sb_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		sbfresh_q <= cfg_q)
		else $error("fresh superblock count above pool size");

	// fresh descriptor counter stays within the store
	a_d_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		32'(dfresh_q) <= NUM_DESCRIPTORS)
		else $error("fresh descriptor counter out of range");

endmodule
